// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ows_pkg.sv =====
package ows_pkg;

	typedef enum logic [2:0] {
		OP_FIRST  = 3'd0,
		OP_NEXT   = 3'd1,
		OP_BIT    = 3'd2,
		OP_TARGET = 3'd3,
		OP_SKIP   = 3'd4
	} ows_op_t;

	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
	localparam logic [6:0] ROM_BITS      = 7'd64;
	localparam logic [6:0] FAMILY_LIMIT  = 7'd9;
	localparam logic [6:0] FIRST_POS     = 7'd1;

	typedef struct packed {
		logic [63:0] rom;
		logic [6:0]  last_disc;
		logic [6:0]  last_fam_disc;
		logic        last_dev;
		logic [6:0]  bit_pos;
		logic [6:0]  zero_pos;
		logic [7:0]  crc;
		logic        active;
	} ows_state_t;

	// Search state after reset: everything clear, bit position at one.
	localparam ows_state_t STATE_RESET = '{
		rom:           64'd0,
		last_disc:     7'd0,
		last_fam_disc: 7'd0,
		last_dev:      1'b0,
		bit_pos:       FIRST_POS,
		zero_pos:      7'd0,
		crc:           8'd0,
		active:        1'b0
	};

	typedef struct packed {
		logic write_bit;
		logic search_done;
		logic device_found;
	} ows_flags_t;

	// One bit of the reflected Dallas CRC-8.
	function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
		logic [7:0] shifted;
		shifted = {1'b0, crc[7:1]};
		return (crc[0] ^ b) ? (shifted ^ CRC_POLY_REFL) : shifted;
	endfunction

endpackage

// ===== hw/rtl/ows_step.sv =====
// Next-state and result logic for one item of the ROM search.
module ows_step import ows_pkg::*; (
	input  ows_state_t  cur,
	input  logic [2:0]  opcode,
	input  logic        id_bit,
	input  logic        complement_bit,
	input  logic        presence,
	input  logic [7:0]  target_family,
	output ows_state_t  nxt,
	output ows_flags_t  flags
);

	logic [5:0] idx;
	logic       dir;
	logic [6:0] pos;

	assign pos = cur.bit_pos;
	assign idx = pos[5:0] - 6'd1;

	always_comb begin
		nxt   = cur;
		flags = '0;
		dir   = 1'b0;
		unique case (opcode)
			OP_FIRST, OP_NEXT: begin
				nxt.active    = 1'b0;
				if (opcode == OP_FIRST) begin
					nxt.last_disc     = '0;
					nxt.last_dev      = 1'b0;
					nxt.last_fam_disc = '0;
				end
				nxt.bit_pos   = FIRST_POS;
				nxt.zero_pos  = '0;
				nxt.crc       = '0;
				if (nxt.last_dev || !presence) begin
					nxt.last_disc     = '0;
					nxt.last_dev      = 1'b0;
					nxt.last_fam_disc = '0;
					flags.search_done = 1'b1;
				end else begin
					nxt.active = 1'b1;
				end
			end
			OP_BIT: begin
				if (cur.active) begin
					if (id_bit && complement_bit) begin
						nxt.active        = 1'b0;
						nxt.last_disc     = '0;
						nxt.last_dev      = 1'b0;
						nxt.last_fam_disc = '0;
						flags.search_done = 1'b1;
					end else begin
						if (id_bit != complement_bit) begin
							dir = id_bit;
						end else begin
							if (pos < cur.last_disc) begin
								dir = cur.rom[idx];
							end else begin
								dir = (pos == cur.last_disc);
							end
							if (!dir) begin
								nxt.zero_pos = pos;
								if (pos < FAMILY_LIMIT) begin
									nxt.last_fam_disc = pos;
								end
							end
						end
						nxt.rom[idx]    = dir;
						flags.write_bit = dir;
						nxt.crc         = crc8_bit(cur.crc, dir);
						nxt.bit_pos     = pos + 7'd1;
						if (pos >= ROM_BITS) begin
							nxt.active        = 1'b0;
							flags.search_done = 1'b1;
							if (nxt.crc == 8'd0) begin
								nxt.last_disc = nxt.zero_pos;
								if (nxt.zero_pos == 7'd0) begin
									nxt.last_dev = 1'b1;
								end
								flags.device_found = 1'b1;
							end
							if (!flags.device_found || nxt.rom[7:0] == 8'd0) begin
								nxt.last_disc      = '0;
								nxt.last_dev       = 1'b0;
								nxt.last_fam_disc  = '0;
								flags.device_found = 1'b0;
							end
						end
					end
				end
			end
			OP_TARGET: begin
				nxt.active        = 1'b0;
				nxt.rom           = {56'd0, target_family};
				nxt.last_disc     = ROM_BITS;
				nxt.last_fam_disc = '0;
				nxt.last_dev      = 1'b0;
			end
			OP_SKIP: begin
				nxt.active        = 1'b0;
				nxt.last_disc     = cur.last_fam_disc;
				nxt.last_fam_disc = '0;
				if (cur.last_fam_disc == 7'd0) begin
					nxt.last_dev = 1'b1;
				end
			end
			default: begin
				// Unused opcodes leave everything as it is.
			end
		endcase
	end

endmodule

// ===== hw/rtl/onewire_rom_search_top.sv =====
// Channel | Handshake                | Payload
// item    | item_valid / item_stall  | opcode, id_bit, complement_bit, presence, target_family
// result  | res_valid / res_stall    | write_bit, search_done, device_found, rom_code,
//         |                          | last_device
//
// Each item passes through the input register and then the result register on
// its way to its result. One item is accepted every cycle while the result
// channel is not stalled; the search state registers take one update per item.
// Reset (arst_n low) clears the search state, with the bit position at one.
// A stalled result holds; the input register keeps taking items until it is
// full behind a stalled result, then item_stall rises.
`include "assert_macros.svh"

module onewire_rom_search_top import ows_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  opcode,
	input  logic        id_bit,
	input  logic        complement_bit,
	input  logic        presence,
	input  logic [7:0]  target_family,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        write_bit,
	output logic        search_done,
	output logic        device_found,
	output logic [63:0] rom_code,
	output logic        last_device
);

	// Input register: holds one accepted item until the state update takes it.
	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic        id_bit_s1;
	logic        comp_bit_s1;
	logic        presence_s1;
	logic [7:0]  family_s1;

	// Search state, updated once for every item that leaves the input register.
	ows_state_t  state_q;
	ows_state_t  state_nxt;
	ows_flags_t  flags_nxt;

	// Result register.
	logic        res_valid_q;
	ows_flags_t  flags_q;
	logic [63:0] rom_q;
	logic        last_dev_q;

	logic        advance;
	logic        accept;

	// The input register moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	ows_step u_step (
		.cur            (state_q),
		.opcode         (opcode_s1),
		.id_bit         (id_bit_s1),
		.complement_bit (comp_bit_s1),
		.presence       (presence_s1),
		.target_family  (family_s1),
		.nxt            (state_nxt),
		.flags          (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1   <= opcode;
			id_bit_s1   <= id_bit;
			comp_bit_s1 <= complement_bit;
			presence_s1 <= presence;
			family_s1   <= target_family;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_q    <= flags_nxt;
			rom_q      <= state_nxt.rom;
			last_dev_q <= state_nxt.last_dev;
		end
	end

	assign res_valid    = res_valid_q;
	assign write_bit    = flags_q.write_bit;
	assign search_done  = flags_q.search_done;
	assign device_found = flags_q.device_found;
	assign rom_code     = rom_q;
	assign last_device  = last_dev_q;

	// A found device always ends the pass and never has a zero family byte.
	`ASSERT_IMPLIES(a_found_done, clk, arst_n, res_valid_q && flags_q.device_found,
		flags_q.search_done && rom_q[7:0] != 8'd0)
	// The input side only stalls behind a held item.
	`ASSERT_IMPLIES(a_stall_held, clk, arst_n, item_stall, valid_s1 && res_valid_q)
	// Every item leaving the input register shows up as a result.
	`ASSERT_NEXT(a_adv_result, clk, arst_n, advance, res_valid_q)
	// A pass that is still running never reports a finished search.
	`ASSERT_IMPLIES(a_active_not_done, clk, arst_n, res_valid_q && state_q.active,
		!flags_q.search_done)

endmodule

// ===== bench/ows_search_monitor.sv =====
`timescale 1ns / 100ps

// Watches both channels of the ROM search engine. It keeps its own copy of the
// search state, works out the result of every accepted item and compares each
// accepted result with the oldest one still awaited.
module ows_search_monitor import ows_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [2:0]  opcode,
	input  logic        id_bit,
	input  logic        complement_bit,
	input  logic        presence,
	input  logic [7:0]  target_family,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic        write_bit,
	input  logic        search_done,
	input  logic        device_found,
	input  logic [63:0] rom_code,
	input  logic        last_device,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic        wbit;
		logic        done;
		logic        found;
		logic [63:0] rom;
		logic        last;
	} search_result_t;

	search_result_t awaited[$];

	logic [63:0] rom_q;
	logic [6:0]  last_disc;
	logic [6:0]  last_fam_disc;
	logic [6:0]  bit_pos;
	logic [6:0]  zero_pos;
	logic [7:0]  crc;
	logic        last_dev;
	logic        active;

	function automatic logic [7:0] crc_shift(input logic [7:0] c, input logic b);
		return {1'b0, c[7:1]} ^ ((c[0] ^ b) ? CRC_POLY_REFL : 8'h00);
	endfunction

	// The ROM code itself survives; only the enumeration bookkeeping goes.
	task automatic forget_search();
		last_disc = '0;
		last_dev = 1'b0;
		last_fam_disc = '0;
	endtask

	task automatic step_search(input logic [2:0] op, input logic idb, input logic cmpb,
			input logic pres, input logic [7:0] fam, output search_result_t r);
		logic [6:0] p;
		logic [5:0] idx;
		logic       dir;
		r = '0;
		case (op)
			OP_FIRST, OP_NEXT: begin
				active = 1'b0;
				if (op == OP_FIRST)
					forget_search();
				bit_pos = FIRST_POS;
				zero_pos = '0;
				crc = '0;
				if (last_dev || !pres) begin
					forget_search();
					r.done = 1'b1;
				end else begin
					active = 1'b1;
				end
			end
			OP_BIT: if (active) begin
				if (idb && cmpb) begin
					active = 1'b0;
					forget_search();
					r.done = 1'b1;
				end else begin
					p = bit_pos;
					idx = 6'(p - 7'd1);
					if (idb != cmpb) begin
						dir = idb;
					end else begin
						if (p < last_disc)
							dir = rom_q[idx];
						else
							dir = (p == last_disc);
						if (!dir) begin
							zero_pos = p;
							if (p < FAMILY_LIMIT)
								last_fam_disc = p;
						end
					end
					rom_q[idx] = dir;
					r.wbit = dir;
					crc = crc_shift(crc, dir);
					bit_pos = p + 7'd1;
					if (p >= ROM_BITS) begin
						active = 1'b0;
						r.done = 1'b1;
						if (crc == 8'h00) begin
							last_disc = zero_pos;
							if (last_disc == '0)
								last_dev = 1'b1;
							r.found = 1'b1;
						end
						if (!r.found || rom_q[7:0] == 8'h00) begin
							forget_search();
							r.found = 1'b0;
						end
					end
				end
			end
			OP_TARGET: begin
				active = 1'b0;
				rom_q = {56'd0, fam};
				last_disc = ROM_BITS;
				last_fam_disc = '0;
				last_dev = 1'b0;
			end
			OP_SKIP: begin
				active = 1'b0;
				last_disc = last_fam_disc;
				last_fam_disc = '0;
				if (last_disc == '0)
					last_dev = 1'b1;
			end
			default: ;
		endcase
		r.rom = rom_q;
		r.last = last_dev;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		search_result_t r;
		if (!arst_n) begin
			rom_q = '0;
			last_disc = '0;
			last_fam_disc = '0;
			last_dev = 1'b0;
			bit_pos = FIRST_POS;
			zero_pos = '0;
			crc = '0;
			active = 1'b0;
			awaited.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (awaited.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result arrived with no item awaiting it", $time);
				end else begin
					r = awaited.pop_front();
					check_field("write_bit", 64'(r.wbit), 64'(write_bit));
					check_field("search_done", 64'(r.done), 64'(search_done));
					check_field("device_found", 64'(r.found), 64'(device_found));
					check_field("rom_code", r.rom, rom_code);
					check_field("last_device", 64'(r.last), 64'(last_device));
				end
			end
			if (item_valid && !item_stall) begin
				step_search(opcode, id_bit, complement_bit, presence, target_family, r);
				awaited.push_back(r);
			end
			pending = awaited.size();
		end
	end

endmodule

// ===== bench/onewire_rom_search_top_tb.sv =====
`timescale 1ns / 100ps

// Bench for the 1-Wire ROM search engine. The stimulus side plays the part of
// a bus master: it opens search passes and answers each bit pair the way a
// population of devices on a wired-AND bus would, using the direction bit the
// block hands back. Other passes stream a whole ROM code without waiting, and
// short bursts of random items cover the odd corners. A monitor beside the
// block predicts and checks every result.
module onewire_rom_search_top_tb;
	import ows_pkg::*;

	localparam int ITEM_TARGET = 2000;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_DEVS    = 6;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	typedef enum logic [1:0] {
		SESSION_PLAIN,
		SESSION_TARGETED,
		SESSION_SKIPPING
	} session_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [2:0]  opcode = '0;
	logic        id_bit = 1'b0;
	logic        complement_bit = 1'b0;
	logic        presence = 1'b0;
	logic [7:0]  target_family = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        write_bit;
	logic        search_done;
	logic        device_found;
	logic [63:0] rom_code;
	logic        last_device;

	int errors;
	int pending;

	// Flow bookkeeping for the stimulus side. Items are counted when they are
	// accepted, results when they are taken, so that the master can wait for
	// the answer to the bit pair it has just sent.
	int   n_sent = 0;
	int   n_real = 0;
	int   n_got = 0;
	logic last_wbit = 1'b0;
	logic last_done = 1'b0;

	// Figures for the closing summary.
	int n_passes_ended = 0;
	int n_found = 0;
	int n_last_dev = 0;
	int n_sessions = 0;
	int n_streamed = 0;

	int burst_left = 0;
	int idle_cycles = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	// The simulated bus: ROM codes of the devices that answer the search.
	logic [63:0] devs [MAX_DEVS];
	int          ndev = 0;

	onewire_rom_search_top dut (.*);

	ows_search_monitor search_mon (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver changes its habits every so often: some stretches take
	// every result, others stall lightly, heavily, or on and off in turn.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(3));
				stall_left <= $urandom_range(5, 120);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE:  res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(3) != 0);
				default:     res_stall <= ~res_stall;
			endcase
		end
	end

	// Follows the results that leave the block, for the master and the summary.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_got <= n_got + 1;
			last_wbit <= write_bit;
			last_done <= search_done;
			if (search_done)
				n_passes_ended <= n_passes_ended + 1;
			if (device_found)
				n_found <= n_found + 1;
			if (device_found && last_device)
				n_last_dev <= n_last_dev + 1;
		end
	end

	// Ends the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item or result moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Appends the Dallas CRC byte to 56 bits of family and serial number, so
	// that the CRC over the whole 64-bit code comes out at zero.
	function automatic logic [63:0] with_crc(input logic [55:0] body);
		logic [7:0] c;
		c = '0;
		for (int i = 0; i < 56; i++)
			c = {1'b0, c[7:1]} ^ ((c[0] ^ body[i]) ? CRC_POLY_REFL : 8'h00);
		return {c, body};
	endfunction

	// Offers one item and returns at the edge where it is accepted. The sender
	// works in bursts; a new burst may open with a gap of idle cycles.
	task automatic push(input logic [2:0] op, input logic idb, input logic cmpb,
			input logic pres, input logic [7:0] fam);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		opcode <= op;
		id_bit <= idb;
		complement_bit <= cmpb;
		presence <= pres;
		target_family <= fam;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n_sent++;
		if (op <= OP_SKIP)
			n_real++;
	endtask

	// Holds the sender back until every result so far has been taken. Always
	// lets at least one edge pass so that valid is never dropped and raised
	// again within one time step.
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (n_got != n_sent);
	endtask

	// One search pass against the simulated bus. Each bit pair is the wired-AND
	// of the devices still taking part, and each waits for the direction that
	// the block chooses, which then drops the devices that disagree. Now and
	// then a pair is garbled to break the pass. Reports whether the pass ended
	// on the begin item itself.
	task automatic search_pass(input logic [2:0] op, output logic ended);
		logic [MAX_DEVS-1:0] alive;
		logic                idb;
		logic                cmpb;
		push(op, 1'($urandom_range(1)), 1'($urandom_range(1)), ($urandom_range(19) != 0),
			8'($urandom_range(255)));
		drain();
		ended = last_done;
		if (ended)
			return;
		alive = '0;
		for (int d = 0; d < ndev; d++)
			alive[d] = 1'b1;
		for (int b = 0; b < 64; b++) begin
			idb = 1'b1;
			cmpb = 1'b1;
			for (int d = 0; d < ndev; d++) begin
				if (alive[d]) begin
					idb &= devs[d][b];
					cmpb &= ~devs[d][b];
				end
			end
			if ($urandom_range(99) == 0) begin
				idb = 1'($urandom_range(1));
				cmpb = 1'($urandom_range(1));
			end
			push(OP_BIT, idb, cmpb, 1'($urandom_range(1)), 8'($urandom_range(255)));
			drain();
			if (last_done)
				return;
			for (int d = 0; d < ndev; d++)
				if (devs[d][b] != last_wbit)
					alive[d] = 1'b0;
		end
	endtask

	// Builds a small population of related devices and enumerates it: from a
	// first search, from a targeted family, or with a family skip after the
	// first device. Devices share a base code with a few bits changed, so
	// discrepancies fall both in the family byte and deep in the serial number.
	task automatic enumerate();
		logic [55:0]   base;
		logic [55:0]   body;
		session_kind_t kind;
		logic          ended;
		int            k;
		base = 56'({$urandom(), $urandom()});
		if ($urandom_range(9) == 0)
			base[7:0] = 8'h00;
		ndev = $urandom_range(1, MAX_DEVS);
		for (int d = 0; d < ndev; d++) begin
			body = base;
			repeat ($urandom_range(1, 3))
				body[$urandom_range(55)] ^= 1'b1;
			devs[d] = with_crc(body);
		end
		kind = session_kind_t'($urandom_range(2));
		if (kind == SESSION_TARGETED) begin
			push(OP_TARGET, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)),
				($urandom_range(3) == 0) ? 8'($urandom_range(255))
				: devs[$urandom_range(ndev - 1)][7:0]);
			search_pass(OP_NEXT, ended);
		end else begin
			search_pass(OP_FIRST, ended);
		end
		if (kind == SESSION_SKIPPING)
			push(OP_SKIP, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 8'($urandom_range(255)));
		k = 0;
		while (!ended && k <= ndev) begin
			search_pass(OP_NEXT, ended);
			k++;
		end
		n_sessions++;
	endtask

	// A begin-first pass sent back to back with no waiting. After a first
	// begin every undecided pair goes the zero way, so answering some zero bits
	// as undecided still walks the block to exactly the chosen code. Some codes
	// carry a zero family byte and some a broken CRC.
	task automatic streamed_pass();
		logic [63:0] code;
		code = with_crc(56'({$urandom(), $urandom()}));
		case ($urandom_range(9))
			0:       code = with_crc({code[55:8], 8'h00});
			1, 2:    code[$urandom_range(63)] ^= 1'b1;
			default: ;
		endcase
		push(OP_FIRST, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
			8'($urandom_range(255)));
		for (int b = 0; b < 64; b++) begin
			if (!code[b] && $urandom_range(3) == 0)
				push(OP_BIT, 1'b0, 1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
			else
				push(OP_BIT, code[b], !code[b], 1'($urandom_range(1)),
					8'($urandom_range(255)));
		end
		n_streamed++;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. A bit pair with no pass open, then the opcodes
		// that the block does not define.
		push(OP_BIT, 1'b1, 1'b0, 1'b1, 8'h00);
		for (int o = OP_SKIP + 1; o < 8; o++)
			push(3'(o), 1'b1, 1'b1, 1'b1, 8'hFF);
		// No presence pulse on either kind of begin.
		push(OP_FIRST, 1'b0, 1'b0, 1'b0, 8'hFF);
		push(OP_NEXT, 1'b1, 1'b1, 1'b0, 8'h00);
		// Target the highest family, then skip with no family discrepancy
		// recorded, which marks the last device; the next begin then ends at
		// once and starts over.
		push(OP_TARGET, 1'b0, 1'b0, 1'b0, 8'hFF);
		push(OP_SKIP, 1'b0, 1'b0, 1'b0, 8'h00);
		push(OP_NEXT, 1'b0, 1'b0, 1'b1, 8'h00);
		// A both-ones pair right after a begin.
		push(OP_FIRST, 1'b0, 1'b0, 1'b1, 8'h00);
		push(OP_BIT, 1'b1, 1'b1, 1'b0, 8'h00);
		// A begin that lands on an open pass, then a target that aborts the
		// new one, so the following pair is ignored.
		push(OP_FIRST, 1'b0, 1'b0, 1'b1, 8'h00);
		push(OP_BIT, 1'b0, 1'b1, 1'b0, 8'h00);
		push(OP_NEXT, 1'b0, 1'b0, 1'b1, 8'h00);
		push(OP_BIT, 1'b1, 1'b0, 1'b0, 8'hFF);
		push(OP_TARGET, 1'b1, 1'b0, 1'b1, 8'h00);
		push(OP_BIT, 1'b0, 1'b0, 1'b1, 8'h00);
		// A skip that aborts an open pass.
		push(OP_FIRST, 1'b1, 1'b1, 1'b1, 8'hFF);
		push(OP_SKIP, 1'b0, 1'b0, 1'b0, 8'h00);
		push(OP_BIT, 1'b0, 1'b0, 1'b0, 8'h00);
		drain();

		// Random part: mostly well-formed enumerations and streamed passes,
		// with some bursts of arbitrary items in between. Every now and then
		// the sender waits for the block to empty completely.
		while (n_real < ITEM_TARGET) begin
			case ($urandom_range(9))
				0, 1, 2, 3: enumerate();
				4, 5, 6, 7: streamed_pass();
				default: begin
					repeat ($urandom_range(1, 8))
						push(3'($urandom_range(7)), 1'($urandom_range(1)),
							1'($urandom_range(1)), 1'($urandom_range(1)),
							8'($urandom_range(255)));
				end
			endcase
			if ($urandom_range(15) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d items: %0d enumeration sessions and %0d streamed passes.",
			n_sent, n_sessions, n_streamed);
		$display("Search passes ended: %0d, devices found: %0d, last device reached: %0d.",
			n_passes_ended, n_found, n_last_dev);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ows_pkg.sv
hw/rtl/ows_step.sv
hw/rtl/onewire_rom_search_top.sv
bench/ows_search_monitor.sv
bench/onewire_rom_search_top_tb.sv
